// ===== src/ijac_pkg.sv =====
// ----------------------------------------------------------------------------
// ijac_pkg: shared types, constants and arithmetic helpers
// Q16.16 / Q32.32 saturation and conversion, input and result structures.
// ----------------------------------------------------------------------------
package ijac_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned AccW  = 64;
  localparam logic signed [31:0] OneQ = 32'sd65536;

  localparam logic [0:0] CfgDimension = 1'b0;
  localparam logic [0:0] CfgParMode   = 1'b1;

  typedef struct packed {
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic signed [31:0] ref_z;
    logic signed [31:0] basis_value;
    logic signed [31:0] grad_x;
    logic signed [31:0] grad_y;
    logic signed [31:0] grad_z;
    logic signed [31:0] node_x;
    logic signed [31:0] node_y;
    logic signed [31:0] node_z;
    logic               last_basis;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         row_index;
    logic signed [31:0] inv_col0;
    logic signed [31:0] inv_col1;
    logic signed [31:0] inv_col2;
    logic signed [31:0] phys_coord;
    logic signed [31:0] jac_det;
    logic               singular;
    logic               last_row;
  } out_item_t;

  // Saturating add of two 64-bit signed values
  function automatic logic signed [63:0] sadd64(logic signed [63:0] a,
                                                logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) sadd64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else sadd64 = s[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  // Q32.32 to Q16.16 with round-half-up and saturation
  function automatic logic signed [31:0] to_q16(logic signed [63:0] v);
    logic signed [64:0] r;
    r = {v[63], v} + 65'sd32768;
    r = r >>> 16;
    if (r > 65'sd2147483647) to_q16 = 32'sh7fffffff;
    else if (r < -65'sd2147483648) to_q16 = 32'sh80000000;
    else to_q16 = r[31:0];
  endfunction

endpackage

// ===== src/ijac_if.sv =====
// ----------------------------------------------------------------------------
// ijac_if: valid/ready channel
// One beat moves one payload of type T.
// ----------------------------------------------------------------------------
interface ijac_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/ijac_front.sv =====
// ----------------------------------------------------------------------------
// ijac_front: basis accumulator
// Accumulates position and Jacobian sums in parametric mode, one product per
// cycle, and hands completed points to the back part over a valid/ready handshake.
// ----------------------------------------------------------------------------
module ijac_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      par_mode_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  ijac_pkg::in_item_t        in_data_i,
  output logic                      pt_valid_o,
  input  logic                      pt_ready_i,
  output logic signed [11:0][63:0]  pt_acc_o,
  output logic signed [2:0][31:0]   pt_ref_o,
  output logic                      pt_par_o
);
  import ijac_pkg::*;

  typedef enum logic [1:0] {SIdle, SMul, SPush} state_e;

  state_e state_q;
  in_item_t item_q;
  logic signed [11:0][63:0] acc_q;
  logic par_q;
  logic [3:0] idx_q;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;

  // Index 0..2 position, 3..11 jacobian (row-major)
  always_comb begin
    ma = item_q.basis_value;
    mb = item_q.node_x;
    if (idx_q < 4'd3) begin
      ma = item_q.basis_value;
    end else if (idx_q < 4'd6) begin
      ma = item_q.grad_x;
    end else if (idx_q < 4'd9) begin
      ma = item_q.grad_y;
    end else begin
      ma = item_q.grad_z;
    end
    case (idx_q)
      4'd0, 4'd3, 4'd6, 4'd9:  mb = item_q.node_x;
      4'd1, 4'd4, 4'd7, 4'd10: mb = item_q.node_y;
      default:                 mb = item_q.node_z;
    endcase
    prod = ma * mb;
  end

  assign in_ready_o = (state_q == SIdle);
  assign pt_valid_o = (state_q == SPush);
  assign pt_acc_o   = acc_q;
  assign pt_ref_o   = {item_q.ref_z, item_q.ref_y, item_q.ref_x};
  assign pt_par_o   = par_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      acc_q   <= '0;
      idx_q   <= '0;
      par_q   <= 1'b0;
    end else begin
      unique case (state_q)
        SIdle: begin
          if (in_valid_i) begin
            item_q <= in_data_i;
            par_q  <= par_mode_i;
            idx_q  <= '0;
            if (par_mode_i) state_q <= SMul;
            else if (in_data_i.last_basis) state_q <= SPush;
          end
        end
        SMul: begin
          acc_q[idx_q] <= sadd64(acc_q[idx_q], prod);
          idx_q <= idx_q + 4'd1;
          if (idx_q == 4'd11) state_q <= item_q.last_basis ? SPush : SIdle;
        end
        SPush: begin
          if (pt_ready_i) begin
            acc_q   <= '0;
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

// ===== src/ijac_div.sv =====
// ----------------------------------------------------------------------------
// ijac_div: radix-2 signed divider
// Truncating quotient of a 48-bit dividend by a 32-bit divisor, saturated.
// ----------------------------------------------------------------------------
module ijac_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [47:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quo_o
);
  import ijac_pkg::*;

  logic        busy_q, neg_q;
  logic [5:0]  cnt_q;
  logic [47:0] q_q;
  logic [32:0] rem_q;
  logic [31:0] d_q;
  logic [32:0] trial;
  logic signed [49:0] sq;

  assign trial = {rem_q[31:0], q_q[47]} - {1'b0, d_q};
  assign sq = neg_q ? -$signed({2'b00, q_q}) : $signed({2'b00, q_q});
  assign quo_o = sat32(sq[49] ? {{14{1'b1}}, sq[49:0]} >>> 0 : {14'd0, sq});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= !start_i && busy_q && (cnt_q == 6'd1);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd48;
        neg_q  <= num_i[47] ^ den_i[31];
        q_q    <= num_i[47] ? 48'(-num_i) : num_i;
        d_q    <= den_i[31] ? 32'(-den_i) : den_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        if (!trial[32]) begin
          rem_q <= trial;
          q_q   <= {q_q[46:0], 1'b1};
        end else begin
          rem_q <= {rem_q[31:0], q_q[47]};
          q_q   <= {q_q[46:0], 1'b0};
        end
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) busy_q <= 1'b0;
      end
    end
  end
endmodule

// ===== src/ijac_back.sv =====
// ----------------------------------------------------------------------------
// ijac_back: determinant, cofactor and inverse sequencer
// One shared multiplier and divider, steps through the point then emits rows.
// ----------------------------------------------------------------------------
module ijac_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [1:0]               dim_i,
  input  logic                     pt_valid_i,
  output logic                     pt_ready_o,
  input  logic signed [11:0][63:0] pt_acc_i,
  input  logic signed [2:0][31:0]  pt_ref_i,
  input  logic                     pt_par_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output ijac_pkg::out_item_t      out_data_o
);
  import ijac_pkg::*;

  typedef enum logic [2:0] {SIdle, SConv, SCof, SDet, SDiv, SEmit} state_e;

  state_e state_q;
  logic [1:0] d_q, row_q;
  logic signed [2:0][2:0][31:0] jq_q, cof_q, inv_q;
  logic signed [2:0][31:0] phys_q;
  logic signed [31:0] det_q;
  logic signed [63:0] dacc_q;
  logic [3:0] k_q;
  logic [1:0] ki, kj;
  logic sing_q, dstart_q, part_q;
  logic dstart_d;
  logic signed [31:0] det_new;
  logic signed [63:0] m0_q;
  logic signed [31:0] ma, mb;
  logic signed [63:0] prod;
  logic ddone;
  logic signed [31:0] dquo;
  logic [1:0] dsel;

  assign dsel = (dim_i == 2'd0) ? 2'd1 : dim_i;
  assign det_new = to_q16(dacc_q);

  // Entry index to row and column
  always_comb begin
    unique case (k_q)
      4'd0:    {ki, kj} = {2'd0, 2'd0};
      4'd1:    {ki, kj} = {2'd0, 2'd1};
      4'd2:    {ki, kj} = {2'd0, 2'd2};
      4'd3:    {ki, kj} = {2'd1, 2'd0};
      4'd4:    {ki, kj} = {2'd1, 2'd1};
      4'd5:    {ki, kj} = {2'd1, 2'd2};
      4'd6:    {ki, kj} = {2'd2, 2'd0};
      4'd7:    {ki, kj} = {2'd2, 2'd1};
      4'd8:    {ki, kj} = {2'd2, 2'd2};
      default: {ki, kj} = {2'd0, 2'd0};
    endcase
  end

  // Minor operands for 3x3 cofactor ki,kj; phase part_q picks the product; SDet uses row 0
  always_comb begin
    logic [1:0] a, b, c, e;
    a = (ki == 2'd0) ? 2'd1 : 2'd0;
    b = (ki == 2'd2) ? 2'd1 : 2'd2;
    c = (kj == 2'd0) ? 2'd1 : 2'd0;
    e = (kj == 2'd2) ? 2'd1 : 2'd2;
    ma = jq_q[a][c];
    mb = jq_q[b][e];
    if (state_q == SCof && part_q) begin
      ma = jq_q[a][e];
      mb = jq_q[b][c];
    end else if (state_q == SDet) begin
      ma = jq_q[0][kj];
      mb = cof_q[0][kj];
    end
    prod = ma * mb;
  end

  always_comb begin
    dstart_d = 1'b0;
    if (state_q == SDet && k_q == {2'd0, d_q} && det_new != 32'sd0) dstart_d = 1'b1;
    if (state_q == SDiv && ddone && (kj + 2'd1 < d_q || ki + 2'd1 < d_q)) dstart_d = 1'b1;
  end

  ijac_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dstart_q),
    .num_i   ({cof_q[ki][kj], 16'd0}),
    .den_i   (det_q),
    .done_o  (ddone),
    .quo_o   (dquo)
  );

  assign pt_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SEmit);
  always_comb begin
    out_data_o.row_index  = row_q;
    out_data_o.inv_col0   = inv_q[row_q][0];
    out_data_o.inv_col1   = inv_q[row_q][1];
    out_data_o.inv_col2   = inv_q[row_q][2];
    out_data_o.phys_coord = phys_q[row_q];
    out_data_o.jac_det    = det_q;
    out_data_o.singular   = sing_q;
    out_data_o.last_row   = (row_q == d_q - 2'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      dstart_q <= 1'b0;
      part_q   <= 1'b0;
      k_q      <= '0;
      row_q    <= '0;
      d_q      <= 2'd3;
    end else begin
      dstart_q <= dstart_d;
      unique case (state_q)
        SIdle: begin
          if (pt_valid_i) begin
            d_q    <= dsel;
            row_q  <= '0;
            cof_q  <= '0;
            sing_q <= 1'b0;
            for (int i = 0; i < 3; i++) begin
              if (i >= dsel) phys_q[i] <= '0;
              else if (pt_par_i) phys_q[i] <= to_q16(pt_acc_i[i]);
              else phys_q[i] <= pt_ref_i[i];
              for (int j = 0; j < 3; j++) begin
                if (pt_par_i && i < dsel && j < dsel)
                  jq_q[i][j] <= to_q16(pt_acc_i[3 + 3*i + j]);
                else jq_q[i][j] <= '0;
                if (!pt_par_i && i == j && i < dsel) inv_q[i][j] <= OneQ;
                else inv_q[i][j] <= '0;
              end
            end
            if (pt_par_i) begin
              state_q <= SConv;
            end else begin
              det_q   <= OneQ;
              state_q <= SEmit;
            end
          end
        end
        SConv: begin
          if (d_q == 2'd1) begin
            cof_q[0][0] <= OneQ;
            k_q <= '0;
            dacc_q <= '0;
            state_q <= SDet;
          end else if (d_q == 2'd2) begin
            cof_q[0][0] <= jq_q[1][1];
            cof_q[0][1] <= sat32(-64'(signed'(jq_q[1][0])));
            cof_q[1][0] <= sat32(-64'(signed'(jq_q[0][1])));
            cof_q[1][1] <= jq_q[0][0];
            k_q <= '0;
            dacc_q <= '0;
            state_q <= SDet;
          end else begin
            k_q <= '0;
            part_q <= 1'b0;
            state_q <= SCof;
          end
        end
        SCof: begin
          if (!part_q) begin
            m0_q <= prod;
            part_q <= 1'b1;
          end else begin
            logic signed [63:0] m;
            m = sadd64(m0_q, -prod);
            if (ki[0] ^ kj[0]) m = (m == {1'b1, 63'd0}) ? {1'b0, {63{1'b1}}} : -m;
            cof_q[ki][kj] <= to_q16(m);
            part_q <= 1'b0;
            if (k_q == 4'd8) begin
              k_q <= '0;
              dacc_q <= '0;
              state_q <= SDet;
            end else k_q <= k_q + 4'd1;
          end
        end
        SDet: begin
          if (k_q == {2'd0, d_q}) begin
            det_q <= det_new;
            if (det_new == 32'sd0) begin
              sing_q  <= 1'b1;
              state_q <= SEmit;
            end else begin
              k_q <= '0;
              state_q <= SDiv;
            end
          end else begin
            dacc_q <= sadd64(dacc_q, prod);
            k_q <= k_q + 4'd1;
          end
        end
        SDiv: begin
          if (ddone) begin
            inv_q[ki][kj] <= dquo;
            if (kj + 2'd1 < d_q) begin
              k_q <= k_q + 4'd1;
            end else if (ki + 2'd1 < d_q) begin
              k_q <= 4'(3 * (ki + 2'd1));
            end else state_q <= SEmit;
          end
        end
        SEmit: begin
          if (out_ready_i) begin
            row_q <= row_q + 2'd1;
            if (row_q == d_q - 2'd1) state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

// ===== src/isoparametric_jacobian_unit_core.sv =====
// ----------------------------------------------------------------------------
// isoparametric_jacobian_unit_core: per-point Jacobian, determinant, inverse
// Each basis beat is taken by the accumulator and then, in parametric mode,
// multiplied into its sums on the accumulator's own multiplier. After the last
// beat of a point the back part computes cofactors and determinant, then each
// inverse entry on its bit-serial divider (up to 9 entries), then emits one row
// per cycle while the output is ready; the accumulator may take the next point
// meanwhile.
// ----------------------------------------------------------------------------
module isoparametric_jacobian_unit_core #(
  parameter int unsigned MAX_DIM = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [1:0] cfg_data_i,
  ijac_if.sink       in_if,
  ijac_if.source     out_if
);
  import ijac_pkg::*;

  logic [1:0] dim_q;
  logic       par_q;
  logic       pt_valid, pt_ready, pt_par;
  logic signed [11:0][63:0] pt_acc;
  logic signed [2:0][31:0]  pt_ref;
  logic [1:0] dim_eff;

  assign dim_eff = (dim_q > 2'(MAX_DIM)) ? 2'(MAX_DIM) : dim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= 2'd3;
      par_q <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgDimension) dim_q <= cfg_data_i;
      if (cfg_idx_i == CfgParMode)   par_q <= cfg_data_i[0];
    end
  end

  ijac_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .par_mode_i (par_q),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .in_data_i  (in_if.data),
    .pt_valid_o (pt_valid),
    .pt_ready_i (pt_ready),
    .pt_acc_o   (pt_acc),
    .pt_ref_o   (pt_ref),
    .pt_par_o   (pt_par)
  );

  ijac_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dim_i       (dim_eff),
    .pt_valid_i  (pt_valid),
    .pt_ready_o  (pt_ready),
    .pt_acc_i    (pt_acc),
    .pt_ref_i    (pt_ref),
    .pt_par_i    (pt_par),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_data_o  (out_if.data)
  );
endmodule

// ===== tb/isoparametric_jacobian_unit_core_test.sv =====
// ----------------------------------------------------------------------------
// isoparametric_jacobian_unit_core_test: self-checking bench for the core
// Drives basis beats through a directed table and then random points over
// several dimension and mode settings. Every result row is checked against
// an in-bench Jacobian, determinant and inverse calculation.
// ----------------------------------------------------------------------------
module isoparametric_jacobian_unit_core_test;
  import ijac_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles   = 600;

  typedef struct {
    in_item_t   item;
    logic       has_row0;
    out_item_t  row0;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_idx_i = '0;
  logic [1:0] cfg_data_i = '0;

  ijac_if #(.T(in_item_t))  in_if ();
  ijac_if #(.T(out_item_t)) out_if ();

  isoparametric_jacobian_unit_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_if(in_if.sink), .out_if(out_if.source)
  );

  always #5 clk_i = ~clk_i;

  logic [1:0] dim_reg;
  logic       par_reg;
  logic signed [63:0] pos_sum [3];
  logic signed [63:0] jac_sum [9];
  out_item_t  rows_pending [$];
  out_item_t  pinned_rows [$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit          no_idle = 1'b0;
  bit          timed_out = 1'b0;

  function automatic logic signed [63:0] sadd(logic signed [63:0] a,
                                              logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] round_q16(logic signed [63:0] v);
    logic signed [64:0] r;
    r = {v[63], v} + 65'sd32768;
    r = r >>> 16;
    if (r > 65'sd2147483647) return 32'sh7fffffff;
    if (r < -65'sd2147483648) return 32'sh80000000;
    return r[31:0];
  endfunction

  task automatic clear_sums();
    for (int i = 0; i < 3; i++) pos_sum[i] = '0;
    for (int i = 0; i < 9; i++) jac_sum[i] = '0;
  endtask

  // accumulate one beat and, on the last, queue the rows it produces
  task automatic predict_point(in_item_t it);
    logic signed [63:0] rv [3], gv [3], nv [3];
    logic signed [63:0] jq [3][3], cof [3][3], inv [3][3], phys [3];
    logic signed [63:0] det, acc, m;
    int d, a, b, c, e;
    out_item_t o;
    rv = '{it.ref_x, it.ref_y, it.ref_z};
    gv = '{it.grad_x, it.grad_y, it.grad_z};
    nv = '{it.node_x, it.node_y, it.node_z};
    d = (dim_reg == 0) ? 1 : int'(dim_reg);
    if (par_reg) begin
      for (int i = 0; i < 3; i++) begin
        pos_sum[i] = sadd(pos_sum[i], 64'(signed'(it.basis_value)) * nv[i]);
        for (int j = 0; j < 3; j++) jac_sum[i*3+j] = sadd(jac_sum[i*3+j], gv[i] * nv[j]);
      end
    end
    if (!it.last_basis) return;
    for (int i = 0; i < 3; i++) begin
      phys[i] = 0;
      for (int j = 0; j < 3; j++) begin
        jq[i][j] = 0; cof[i][j] = 0; inv[i][j] = 0;
      end
    end
    if (par_reg) begin
      for (int i = 0; i < d; i++)
        for (int j = 0; j < d; j++) jq[i][j] = round_q16(jac_sum[i*3+j]);
      for (int i = 0; i < d; i++)
        for (int j = 0; j < d; j++) begin
          if (d == 1) cof[i][j] = 65536;
          else if (d == 2) begin
            m = jq[1-i][1-j];
            cof[i][j] = ((i + j) % 2) ? clamp32(-m) : m;
          end else begin
            a = (i == 0) ? 1 : 0; b = (i == 2) ? 1 : 2;
            c = (j == 0) ? 1 : 0; e = (j == 2) ? 1 : 2;
            m = sadd(jq[a][c] * jq[b][e], -(jq[a][e] * jq[b][c]));
            if ((i + j) % 2) m = (m == {1'b1, 63'd0}) ? {1'b0, {63{1'b1}}} : -m;
            cof[i][j] = round_q16(m);
          end
        end
      acc = 0;
      for (int k = 0; k < d; k++) acc = sadd(acc, jq[0][k] * cof[0][k]);
      det = round_q16(acc);
      if (det != 0)
        for (int i = 0; i < d; i++)
          for (int j = 0; j < d; j++) inv[i][j] = clamp32((cof[i][j] * 65536) / det);
      for (int i = 0; i < d; i++) phys[i] = round_q16(pos_sum[i]);
    end else begin
      det = 65536;
      for (int i = 0; i < d; i++) begin
        inv[i][i] = 65536;
        phys[i] = rv[i];
      end
    end
    clear_sums();
    for (int i = 0; i < d; i++) begin
      o.row_index = 2'(i);
      o.inv_col0 = inv[i][0][31:0];
      o.inv_col1 = inv[i][1][31:0];
      o.inv_col2 = inv[i][2][31:0];
      o.phys_coord = phys[i][31:0];
      o.jac_det = det[31:0];
      o.singular = par_reg && det == 0;
      o.last_row = (i == d - 1);
      rows_pending.push_back(o);
    end
  endtask

  task automatic write_reg(logic [0:0] idx, logic [1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgDimension) dim_reg = val; else par_reg = val[0];
  endtask

  task automatic wait_idle();
    while (rows_pending.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 32'(signed'($urandom_range(0, 131072)) - 65536);
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return 32'($urandom);
      default: return 32'(signed'($urandom_range(0, 262144)) - 131072);
    endcase
  endfunction

  function automatic in_item_t rand_beat(logic last);
    in_item_t it;
    it.ref_x = rand_q(); it.ref_y = rand_q(); it.ref_z = rand_q();
    it.basis_value = rand_q();
    it.grad_x = rand_q(); it.grad_y = rand_q(); it.grad_z = rand_q();
    it.node_x = rand_q(); it.node_y = rand_q(); it.node_z = rand_q();
    it.last_basis = last;
    return it;
  endfunction

  task automatic send_beat(in_item_t it);
    if (!no_idle)
      while ($urandom_range(0, 99) < 16) begin
        in_if.valid <= 1'b0;
        @(negedge clk_i);
      end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    @(posedge clk_i);
    while (!in_if.ready && !timed_out) @(posedge clk_i);
    predict_point(it);
    @(negedge clk_i);
  endtask

  task automatic release_bus();
    in_if.valid <= 1'b0;
  endtask

  // output side: random back-pressure and row checking
  always @(negedge clk_i)
    out_if.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 16);

  always @(posedge clk_i) begin
    out_item_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (rows_pending.size() == 0) begin
        $error("unexpected row %0d", got.row_index);
        errors++;
      end else begin
        want = rows_pending.pop_front();
        if (pinned_rows.size() != 0 && got.row_index == 0) begin
          if (got !== pinned_rows[0]) begin
            $error("table row: expected %h actual %h", pinned_rows[0], got);
            errors++;
          end
          void'(pinned_rows.pop_front());
        end
        if (got.row_index !== want.row_index) begin
          $error("row_index expected %0d actual %0d", want.row_index, got.row_index); errors++;
        end
        if (got.inv_col0 !== want.inv_col0) begin
          $error("inv_col0 expected %0d actual %0d", want.inv_col0, got.inv_col0); errors++;
        end
        if (got.inv_col1 !== want.inv_col1) begin
          $error("inv_col1 expected %0d actual %0d", want.inv_col1, got.inv_col1); errors++;
        end
        if (got.inv_col2 !== want.inv_col2) begin
          $error("inv_col2 expected %0d actual %0d", want.inv_col2, got.inv_col2); errors++;
        end
        if (got.phys_coord !== want.phys_coord) begin
          $error("phys_coord expected %0d actual %0d", want.phys_coord, got.phys_coord);
          errors++;
        end
        if (got.jac_det !== want.jac_det) begin
          $error("jac_det expected %0d actual %0d", want.jac_det, got.jac_det); errors++;
        end
        if (got.singular !== want.singular) begin
          $error("singular expected %0d actual %0d", want.singular, got.singular); errors++;
        end
        if (got.last_row !== want.last_row) begin
          $error("last_row expected %0d actual %0d", want.last_row, got.last_row); errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic in_item_t beat(logic signed [31:0] rx, ry, rz, bv, gx, gy, gz,
                                    nx, ny, nz, logic last);
    in_item_t it;
    it = '{rx, ry, rz, bv, gx, gy, gz, nx, ny, nz, last};
    return it;
  endfunction

  function automatic out_item_t row0(logic signed [31:0] c0, c1, c2, ph, dt,
                                     logic sg, logic lr);
    out_item_t o;
    o = '{2'd0, c0, c1, c2, ph, dt, sg, lr};
    return o;
  endfunction

  initial begin
    dir_row_t tbl [$];
    logic [1:0] dims [4] = '{2'd1, 2'd2, 2'd3, 2'd0};
    int nbeats, sent;
    localparam logic signed [31:0] One = 32'sd65536;
    localparam logic signed [31:0] Mx = 32'sh7fffffff;
    localparam logic signed [31:0] Mn = 32'sh80000000;

    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    dim_reg = 2'd3; par_reg = 1'b1;
    clear_sums();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset settings, dimension 3: identity Jacobian over three beats
    tbl.push_back('{beat(0, 0, 0, One, One, 0, 0, One, 0, 0, 0), 0, '0});
    tbl.push_back('{beat(0, 0, 0, 0, 0, One, 0, 0, One, 0, 0), 0, '0});
    tbl.push_back('{beat(0, 0, 0, 0, 0, 0, One, 0, 0, One, 1), 1,
                    row0(One, 0, 0, One, One, 0, 0)});
    // all-zero point is singular
    tbl.push_back('{beat(Mx, Mn, 1, 0, 0, 0, 0, 0, 0, 0, 1), 1,
                    row0(0, 0, 0, 0, 0, 1, 0)});
    // extremes, saturating sums
    tbl.push_back('{beat(Mx, Mx, Mx, Mx, Mx, Mx, Mx, Mx, Mx, Mx, 0), 0, '0});
    tbl.push_back('{beat(Mx, Mx, Mx, Mx, Mx, Mx, Mx, Mx, Mx, Mx, 1), 0, '0});
    tbl.push_back('{beat(Mn, Mn, Mn, Mn, Mn, Mn, Mn, Mn, Mn, Mn, 1), 0, '0});
    tbl.push_back('{beat(-1, -1, -1, -1, -1, Mn, -1, Mx, Mn, -1, 1), 0, '0});
    tbl.push_back('{beat(0, 0, 0, 32'sd131072, 32'sd196608, 32'sd65536, -32'sd65536,
                         32'sd98304, -32'sd32768, 32'sd65536, 1), 0, '0});
    foreach (tbl[k]) begin
      if (tbl[k].has_row0) pinned_rows.push_back(tbl[k].row0);
      send_beat(tbl[k].item);
    end
    release_bus();
    wait_idle();

    // pass-through mode with extreme reference coordinates
    write_reg(CfgParMode, 2'd0);
    tbl.delete();
    tbl.push_back('{beat(Mx, Mn, 5, 7, 7, 7, 7, 7, 7, 7, 0), 0, '0});
    tbl.push_back('{beat(Mn, Mx, -1, 0, 0, 0, 0, 0, 0, 0, 1), 1,
                    row0(One, 0, 0, Mn, One, 0, 0)});
    foreach (tbl[k]) begin
      if (tbl[k].has_row0) pinned_rows.push_back(tbl[k].row0);
      send_beat(tbl[k].item);
    end
    release_bus();
    wait_idle();
    // mode change mid-point keeps partial sums
    write_reg(CfgParMode, 2'd1);
    send_beat(beat(0, 0, 0, One, One, 0, 0, One, 0, 0, 0));
    release_bus();
    wait_idle();
    write_reg(CfgParMode, 2'd0);
    send_beat(rand_beat(0));
    release_bus();
    wait_idle();
    write_reg(CfgParMode, 2'd1);
    send_beat(rand_beat(1));
    release_bus();
    wait_idle();

    // random points over every dimension and both modes
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CfgDimension, dims[ph % 4]);
      write_reg(CfgParMode, (ph == 5) ? 2'd0 : 2'd1);
      no_idle = (ph == 3);
      for (int p = 0; p < 14; p++) begin
        nbeats = (dims[ph % 4] == 1) ? $urandom_range(1, 2) : $urandom_range(1, 4);
        for (int b = 0; b < nbeats; b++) begin
          send_beat(rand_beat(b == nbeats - 1));
          sent++;
        end
        // a single dimension change in the middle of a point
        if (p == 7 && ph == 6) begin
          release_bus();
          send_beat(rand_beat(0));
          release_bus();
          wait_idle();
          write_reg(CfgDimension, 2'd2);
        end
      end
      release_bus();
      wait_idle();
    end
    no_idle = 1'b0;

    if (errors == 0 && rows_pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
